@@ design/bdq_pkg.sv @@
// bdq_pkg: types, constants and pointer helpers for the bounded deque core
// used by bdq_ram's instance in the top level, by the top level and by its checker
`default_nettype none

package bdq_pkg;

  localparam int DEPTH = 8;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = PTR_W + 1;
  localparam int DATA_W = 32;
  localparam int CMD_W = 3;
  localparam int POS_W = 3;
  localparam int FILL_COUNT_W = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_POP_BACK   = 3'd1,
    CMD_CLEAR      = 3'd2,
    CMD_PUSH_FRONT = 3'd3,
    CMD_POP_FRONT  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_LIST = 1'b1
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  item;
    logic [POS_W-1:0]          position;
    logic                      has_item;
    logic                      last;
    logic [FILL_COUNT_W-1:0]   fill_count;
    status_t                   status;
  } rsp_t;

  // circular add, offset never exceeds DEPTH
  function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] offset);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(offset);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] base);
    logic [PTR_W-1:0] res;
    if (base == '0) begin
      res = PTR_W'(DEPTH - 1);
    end else begin
      res = base - 1'b1;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ design/bdq_ram.sv @@
// bdq_ram: generic single-write, single-read synchronous ram with registered read
// no dependencies
`default_nettype none

module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ design/bounded_deque_with_listing_core.sv @@
// bounded_deque_with_listing_core: circular deque in a ram, lists contents after each command
// depends on bdq_pkg and bdq_ram
//
//   channel | direction | payload | transaction
//   req     | in        | req_t   | req_valid & !req_stall
//   rsp     | out       | rsp_t   | rsp_valid & !rsp_stall
//
// a command is taken in the idle state; the first entry then reaches the output
// register through the ram read register (an empty list goes straight to it), then
// one result per cycle while rsp_stall is low; the ram's single read port paces
// the listing
// req_stall stays high until the last result sits in the output register
// reset clears head, fill and control at once; entries are unknown until written
// rsp_stall holds the output register and the ram read data in place
`default_nettype none

module bounded_deque_with_listing_core
  import bdq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  state_t           state, state_next;
  logic [PTR_W-1:0] head, head_next;
  logic [CNT_W-1:0] fill, fill_next;
  status_t          status, status_next;
  logic [CNT_W-1:0] rd_idx;
  logic [CNT_W-1:0] cap_idx;
  logic             rv;
  logic             ov;

  logic              accept;
  logic              issue;
  logic              cap_fire;
  logic              cap_last;
  logic              we;
  logic [PTR_W-1:0]  waddr;
  logic [PTR_W-1:0]  raddr;
  logic [DATA_W-1:0] rdata;
  logic              full;
  logic              empty;

  assign full  = (fill == CNT_W'(DEPTH));
  assign empty = (fill == '0);

  bdq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(req.value),
    .re   (issue),
    .raddr(raddr),
    .rdata(rdata)
  );

  // command decode
  always_comb begin
    head_next   = head;
    fill_next   = fill;
    status_next = ST_OK;
    we          = 1'b0;
    waddr       = ptr_add(head, fill);
    case (req.command)
      CMD_PUSH_BACK: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          we        = 1'b1;
          fill_next = fill + 1'b1;
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          fill_next = fill - 1'b1;
        end
      end
      CMD_CLEAR: begin
        fill_next = '0;
      end
      CMD_PUSH_FRONT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          we        = 1'b1;
          head_next = ptr_dec(head);
          waddr     = head_next;
          fill_next = fill + 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          head_next = ptr_add(head, CNT_W'(1));
          fill_next = fill - 1'b1;
        end
      end
      default: begin
      end
    endcase
    we = we & accept;
  end

  // fsm next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_LIST;
        end
      end
      S_LIST: begin
        if (cap_fire && cap_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // fsm outputs
  always_comb begin
    req_stall = 1'b1;
    accept    = 1'b0;
    issue     = 1'b0;
    cap_fire  = 1'b0;
    case (state)
      S_IDLE: begin
        req_stall = 1'b0;
        accept    = req_valid;
      end
      S_LIST: begin
        cap_fire = (!ov || !rsp_stall) && (rv || empty);
        issue    = (rd_idx < fill) && (!rv || cap_fire);
      end
      default: begin
      end
    endcase
  end

  assign raddr    = ptr_add(head, rd_idx);
  assign cap_last = empty || (cap_idx == fill - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      head    <= '0;
      fill    <= '0;
      status  <= ST_OK;
      rd_idx  <= '0;
      cap_idx <= '0;
      rv      <= 1'b0;
      ov      <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        head    <= head_next;
        fill    <= fill_next;
        status  <= status_next;
        rd_idx  <= '0;
        cap_idx <= '0;
      end else begin
        if (issue) begin
          rd_idx <= rd_idx + 1'b1;
        end
        if (cap_fire) begin
          cap_idx <= cap_idx + 1'b1;
        end
      end
      if (issue) begin
        rv <= 1'b1;
      end else if (cap_fire) begin
        rv <= 1'b0;
      end
      if (cap_fire) begin
        ov <= 1'b1;
      end else if (!rsp_stall) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cap_fire) begin
      rsp.item       <= empty ? '0 : rdata;
      rsp.position   <= POS_W'(cap_idx);
      rsp.has_item   <= !empty;
      rsp.last       <= cap_last;
      rsp.fill_count <= FILL_COUNT_W'(fill);
      rsp.status     <= status;
    end
  end

  assign rsp_valid = ov;

endmodule

`default_nettype wire

@@ design/bdq_checker.sv @@
// bdq_checker: port-level checks for bounded_deque_with_listing_core
// depends on bdq_pkg; bound to the top level below
`default_nettype none

module bdq_checker
  import bdq_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_stall,
  input wire req_t req,
  input wire logic rsp_valid,
  input wire logic rsp_stall,
  input wire rsp_t rsp
);

  // a held result keeps its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // a taken command blocks the next one while it is listed
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("command accepted during listing");

  // empty listing is a single marked result
  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.has_item |->
      rsp.last && rsp.fill_count == '0 && rsp.item == '0 && rsp.position == '0)
    else $error("malformed empty listing");

  // the last entry sits at the back of the list
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.has_item && rsp.last |->
      FILL_COUNT_W'(rsp.position) + 1'b1 == rsp.fill_count)
    else $error("last flag at wrong position");

  // fill never exceeds capacity
  a_fill_cap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.fill_count <= FILL_COUNT_W'(DEPTH))
    else $error("fill count above capacity");

endmodule

bind bounded_deque_with_listing_core bdq_checker u_bdq_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req_valid),
  .req_stall(req_stall),
  .req      (req),
  .rsp_valid(rsp_valid),
  .rsp_stall(rsp_stall),
  .rsp      (rsp)
);

`default_nettype wire
